[hw/rtl/tte_pkg.sv]
// Shared types, constants and helpers for the tap tempo estimator.
// No dependencies; every other file of the block imports this package.
package tte_pkg;

	// Field widths
	localparam int TIME_W  = 32;
	localparam int CFG_W   = 16;
	localparam int REQ_W   = 16;
	localparam int TEMPO_W = 12;

	// Window depth default
	localparam int MAX_TAPS_DEF = 6;

	// Tempo limits in tenths of BPM
	localparam logic [TEMPO_W-1:0] TEMPO_MIN = 12'd200;
	localparam logic [TEMPO_W-1:0] TEMPO_MAX = 12'd3000;

	// Twice the tenths-of-BPM per ms constant, and the bits it needs
	localparam int NUM_SCALE   = 1200000;
	localparam int NUM_SCALE_W = 21;

	// Register reset values
	localparam logic [CFG_W-1:0]   RESET_GAP_DEF  = 16'd2000;
	localparam logic [CFG_W-1:0]   MIN_IV_DEF     = 16'd200;
	localparam logic [CFG_W-1:0]   MAX_IV_DEF     = 16'd3000;
	localparam logic [TEMPO_W-1:0] INIT_TEMPO_DEF = 12'd1200;

	// Item operations
	typedef enum logic {
		OP_TAP     = 1'b0,
		OP_REQUEST = 1'b1
	} op_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_RESET_GAP  = 2'd0,
		REG_MIN_IV     = 2'd1,
		REG_MAX_IV     = 2'd2,
		REG_INIT_TEMPO = 2'd3
	} cfg_reg_t;

	// Controls from the sequencer to the tap window
	typedef struct packed {
		logic update;
		logic acc_start;
		logic acc_step;
	} win_ctrl_t;

	// Status of the serial divider
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Clamp a tempo to the legal range
	function automatic logic [TEMPO_W-1:0] clamp_tempo(input logic [REQ_W-1:0] t);
		logic [TEMPO_W-1:0] r;
		if (t < REQ_W'(TEMPO_MIN)) begin
			r = TEMPO_MIN;
		end else if (t > REQ_W'(TEMPO_MAX)) begin
			r = TEMPO_MAX;
		end else begin
			r = t[TEMPO_W-1:0];
		end
		return r;
	endfunction

endpackage

[hw/rtl/tap_tempo_estimator_top.sv]
// Top level of the tap tempo estimator: channel handshakes, configuration
// registers and the item sequencer. Uses tte_pkg, tte_window and tte_div.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+---------------------------------------------
//   item     | item_valid/item_ready     | opcode, tap_time_ms, tempo_request_tenths
//   result   | result_valid/result_ready | tempo_tenths, tempo_changed, estimate_made,
//            |                           | valid_intervals
//   config   | cfg_valid/cfg_ready       | cfg_index, cfg_data
//
// A tempo request goes straight to the output step. A tap passes through the accumulator
// one interval per cycle, then, when an interval is valid and the sum is non-zero,
// through the serial divider at one quotient bit per cycle.
// One item is in work at a time; the next is taken once the previous result sits in
// the output register. A stalled result holds the sequencer before its last step.
// Reset empties the tap window and loads the register defaults; config is always ready.
module tap_tempo_estimator_top import tte_pkg::*; #(
	parameter int MAX_TAPS = MAX_TAPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// Item channel
	input  logic                item_valid,
	output logic                item_ready,
	input  logic                opcode,
	input  logic [TIME_W-1:0]   tap_time_ms,
	input  logic [REQ_W-1:0]    tempo_request_tenths,
	// Result channel
	output logic                result_valid,
	input  logic                result_ready,
	output logic [TEMPO_W-1:0]  tempo_tenths,
	output logic                tempo_changed,
	output logic                estimate_made,
	output logic [2:0]          valid_intervals,
	// Configuration channel
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [CFG_W-1:0]    cfg_data
);

	localparam int CW    = $clog2(MAX_TAPS);
	localparam int SUM_W = CFG_W + CW;
	localparam int DEN_W = SUM_W + 1;
	localparam int NUM_W = NUM_SCALE_W + CW;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_ACC  = 5'b00010,
		S_PREP = 5'b00100,
		S_DIV  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t              state_q;
	logic [CFG_W-1:0]    reset_gap_q;
	logic [CFG_W-1:0]    min_iv_q;
	logic [CFG_W-1:0]    max_iv_q;
	logic [TEMPO_W-1:0]  cur_tempo_q;
	logic [TEMPO_W-1:0]  new_tempo_q;
	logic                est_q;
	logic [2:0]          nv_out_q;
	logic                res_valid_q;
	logic [TEMPO_W-1:0]  res_tempo_q;
	logic                res_changed_q;
	logic                res_est_q;
	logic [2:0]          res_nv_q;

	logic                item_acc;
	logic                cfg_acc;
	logic                out_free;
	win_ctrl_t           win_ctrl;
	logic                acc_last;
	logic [SUM_W-1:0]    win_sum;
	logic [CW-1:0]       win_nv;
	logic                div_start;
	logic [NUM_W-1:0]    div_numer;
	logic [DEN_W-1:0]    div_denom;
	div_stat_t           div_stat;
	logic [NUM_W-1:0]    div_quot;
	logic [TEMPO_W-1:0]  quot_tempo;
	logic [2:0]          nv_sat;

	assign item_ready = (state_q == S_IDLE);
	assign cfg_ready  = 1'b1;
	assign item_acc   = item_valid && item_ready;
	assign cfg_acc    = cfg_valid && cfg_ready;
	assign out_free   = !res_valid_q || result_ready;

	// Window control: a tap updates the window and opens a new accumulation
	always_comb begin
		win_ctrl.update    = item_acc && (opcode == OP_TAP);
		win_ctrl.acc_start = item_acc && (opcode == OP_TAP);
		win_ctrl.acc_step  = (state_q == S_ACC);
	end

	tte_window #(
		.MAX_TAPS (MAX_TAPS)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (win_ctrl),
		.tap_time  (tap_time_ms),
		.reset_gap (reset_gap_q),
		.min_iv    (min_iv_q),
		.max_iv    (max_iv_q),
		.acc_last  (acc_last),
		.sum       (win_sum),
		.nvalid    (win_nv)
	);

	// Rounded quotient: (2 * 600000 * n + sum) / (2 * sum)
	assign div_start = (state_q == S_PREP) && (win_nv != '0) && (win_sum != '0);
	assign div_numer = NUM_W'(NUM_SCALE) * NUM_W'(win_nv) + NUM_W'(win_sum);
	assign div_denom = {win_sum, 1'b0};

	tte_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (div_numer),
		.denom  (div_denom),
		.stat   (div_stat),
		.quot   (div_quot)
	);

	// Clamp the divider result to the tempo range
	always_comb begin
		if (div_quot > NUM_W'(TEMPO_MAX)) begin
			quot_tempo = TEMPO_MAX;
		end else if (div_quot < NUM_W'(TEMPO_MIN)) begin
			quot_tempo = TEMPO_MIN;
		end else begin
			quot_tempo = div_quot[TEMPO_W-1:0];
		end
	end

	// Report at most seven intervals
	assign nv_sat = (32'(win_nv) > 7) ? 3'd7 : 3'(win_nv);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (item_acc) begin
						state_q <= (opcode == OP_REQUEST) ? S_OUT : S_ACC;
					end
				end
				S_ACC: begin
					if (acc_last) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					state_q <= div_start ? S_DIV : S_OUT;
				end
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hold the pending result of the item in work
	always_ff @(posedge clk) begin
		if (item_acc && (opcode == OP_REQUEST)) begin
			new_tempo_q <= clamp_tempo(tempo_request_tenths);
			est_q       <= 1'b0;
			nv_out_q    <= 3'd0;
		end else if (state_q == S_PREP) begin
			est_q    <= (win_nv != '0);
			nv_out_q <= nv_sat;
			if (win_nv == '0) begin
				new_tempo_q <= cur_tempo_q;
			end else if (win_sum == '0) begin
				new_tempo_q <= TEMPO_MAX;
			end
		end else if ((state_q == S_DIV) && div_stat.done) begin
			new_tempo_q <= quot_tempo;
		end
	end

	// Configuration registers and the current tempo
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_gap_q <= RESET_GAP_DEF;
			min_iv_q    <= MIN_IV_DEF;
			max_iv_q    <= MAX_IV_DEF;
			cur_tempo_q <= clamp_tempo(REQ_W'(INIT_TEMPO_DEF));
		end else if (cfg_acc) begin
			case (cfg_reg_t'(cfg_index))
				REG_RESET_GAP:  reset_gap_q <= cfg_data;
				REG_MIN_IV:     min_iv_q    <= cfg_data;
				REG_MAX_IV:     max_iv_q    <= cfg_data;
				REG_INIT_TEMPO: cur_tempo_q <= clamp_tempo(REQ_W'(cfg_data[TEMPO_W-1:0]));
				default: begin
				end
			endcase
		end else if ((state_q == S_OUT) && out_free) begin
			cur_tempo_q <= new_tempo_q;
		end
	end

	// Output register: load on the last step, drop after the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((state_q == S_OUT) && out_free) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && out_free) begin
			res_tempo_q   <= new_tempo_q;
			res_changed_q <= (new_tempo_q != cur_tempo_q);
			res_est_q     <= est_q;
			res_nv_q      <= nv_out_q;
		end
	end

	assign result_valid    = res_valid_q;
	assign tempo_tenths    = res_tempo_q;
	assign tempo_changed   = res_changed_q;
	assign estimate_made   = res_est_q;
	assign valid_intervals = res_nv_q;

`ifndef ASSERT_OFF
	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item taken while previous item still in work");

	a_tempo_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (tempo_tenths >= TEMPO_MIN) && (tempo_tenths <= TEMPO_MAX))
		else $error("reported tempo outside legal range");

	a_estimate_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (estimate_made == (valid_intervals != 3'd0)))
		else $error("estimate flag disagrees with interval count");

	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide step");
`endif

endmodule

[hw/rtl/tte_window.sv]
// Tap window: last tap time and a shift line of tap intervals, plus the
// serial accumulator that sums in-range intervals one per cycle. Uses tte_pkg.
module tte_window import tte_pkg::*; #(
	parameter int MAX_TAPS = MAX_TAPS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  win_ctrl_t                        ctrl,
	input  logic [TIME_W-1:0]                tap_time,
	input  logic [CFG_W-1:0]                 reset_gap,
	input  logic [CFG_W-1:0]                 min_iv,
	input  logic [CFG_W-1:0]                 max_iv,
	output logic                             acc_last,
	output logic [CFG_W+$clog2(MAX_TAPS)-1:0] sum,
	output logic [$clog2(MAX_TAPS)-1:0]      nvalid
);

	localparam int NIV   = MAX_TAPS - 1;
	localparam int CNT_W = $clog2(MAX_TAPS + 1);
	localparam int CW    = $clog2(MAX_TAPS);
	localparam int SUM_W = CFG_W + CW;

	logic [TIME_W-1:0] iv_q [NIV];
	logic [TIME_W-1:0] last_q;
	logic [CNT_W-1:0]  tap_cnt_q;
	logic [CNT_W-1:0]  acc_cnt_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CW-1:0]     nv_q;

	logic [TIME_W-1:0] gap;
	logic              drop;
	logic [TIME_W-1:0] head;
	logic              in_range;
	logic              live;

	// Gap since the newest stored tap; an empty window or a long gap restarts it
	assign gap  = tap_time - last_q;
	assign drop = (tap_cnt_q == '0) || (gap > TIME_W'(reset_gap));

	// Interval under examination sits at the head of the line
	assign head     = iv_q[0];
	assign in_range = (head >= TIME_W'(min_iv)) && (head <= TIME_W'(max_iv));
	assign live     = (({1'b0, acc_cnt_q} + 1'b1) < {1'b0, tap_cnt_q});
	assign acc_last = (acc_cnt_q == CNT_W'(NIV - 1));

	// Push a new interval, or rotate the line by one during accumulation
	always_ff @(posedge clk) begin
		if (ctrl.update) begin
			last_q <= tap_time;
			if (!drop) begin
				iv_q[0] <= gap;
				for (int k = 1; k < NIV; k++) begin
					iv_q[k] <= iv_q[k-1];
				end
			end
		end else if (ctrl.acc_step) begin
			for (int k = 0; k < NIV - 1; k++) begin
				iv_q[k] <= iv_q[k+1];
			end
			iv_q[NIV-1] <= iv_q[0];
		end
	end

	// Track the number of stored taps, saturating at the window depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_cnt_q <= '0;
		end else if (ctrl.update) begin
			if (drop) begin
				tap_cnt_q <= CNT_W'(1);
			end else if (tap_cnt_q != CNT_W'(MAX_TAPS)) begin
				tap_cnt_q <= tap_cnt_q + 1'b1;
			end
		end
	end

	// Advance the accumulation position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_cnt_q <= '0;
		end else if (ctrl.acc_start) begin
			acc_cnt_q <= '0;
		end else if (ctrl.acc_step) begin
			acc_cnt_q <= acc_cnt_q + 1'b1;
		end
	end

	// Sum and count the in-range intervals
	always_ff @(posedge clk) begin
		if (ctrl.acc_start) begin
			sum_q <= '0;
			nv_q  <= '0;
		end else if (ctrl.acc_step && live && in_range) begin
			sum_q <= sum_q + SUM_W'(head[CFG_W-1:0]);
			nv_q  <= nv_q + 1'b1;
		end
	end

	assign sum    = sum_q;
	assign nvalid = nv_q;

endmodule

[hw/rtl/tte_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle, the dividend
// shifting out at the top while quotient bits shift in. Uses tte_pkg.
module tte_div import tte_pkg::*; #(
	parameter int NUM_W = NUM_SCALE_W + 3,
	parameter int DEN_W = CFG_W + 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	output div_stat_t        stat,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   trial;
	logic             fits;
	logic [DEN_W:0]   diff;

	// Bring down the next dividend bit and try the subtraction
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = (trial >= {1'b0, den_q});
	assign diff  = trial - {1'b0, den_q};

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			den_q <= denom;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], fits};
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	// Count the bit steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(NUM_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = num_q;

endmodule

[tb/tap_tempo_estimator_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for tap_tempo_estimator_top: tap and tempo request traffic
// against a predictor of the tap window and averaging. Depends on tte_pkg and the RTL.
module tap_tempo_estimator_top_tb;
	import tte_pkg::*;

	localparam int WINDOW       = MAX_TAPS_DEF;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int SETTLE       = 60;
	localparam int MAX_REPORTS  = 10;

	typedef enum int {
		RX_ALWAYS,
		RX_RANDOM,
		RX_PERIODIC,
		RX_BURSTY
	} rx_mode_t;

	typedef struct packed {
		logic [TEMPO_W-1:0] tempo;
		logic               changed;
		logic               estimate;
		logic [2:0]         intervals;
	} tempo_result_t;

	// Tracks the tap window and tempo, and holds the tempo results still to come
	class tempo_tracker;
		logic [CFG_W-1:0]   gap_ms;
		logic [CFG_W-1:0]   min_iv;
		logic [CFG_W-1:0]   max_iv;
		logic [TEMPO_W-1:0] init_tempo;
		logic [TEMPO_W-1:0] tempo;
		logic [TIME_W-1:0]  taps [WINDOW];
		int unsigned        ntaps;
		tempo_result_t      expected_tempos[$];
		int unsigned        n_taps, n_requests, n_estimates, n_changes, n_cfg;
		int unsigned        n_checked, n_errors;

		function new();
			gap_ms     = RESET_GAP_DEF;
			min_iv     = MIN_IV_DEF;
			max_iv     = MAX_IV_DEF;
			init_tempo = INIT_TEMPO_DEF;
			tempo      = clamp_tenths(64'(INIT_TEMPO_DEF));
			ntaps      = 0;
		endfunction

		function logic [TEMPO_W-1:0] clamp_tenths(logic [63:0] v);
			if (v < 64'(TEMPO_MIN)) return TEMPO_MIN;
			if (v > 64'(TEMPO_MAX)) return TEMPO_MAX;
			return v[TEMPO_W-1:0];
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] data);
			n_cfg++;
			case (idx)
			REG_RESET_GAP: gap_ms = data;
			REG_MIN_IV:    min_iv = data;
			REG_MAX_IV:    max_iv = data;
			REG_INIT_TEMPO: begin
				init_tempo = data[TEMPO_W-1:0];
				tempo      = clamp_tenths(64'(init_tempo));
			end
			default: ;
			endcase
		endfunction

		// Advance the window for one accepted item and queue the tempo it yields
		function void predict_tempo(op_t op, logic [TIME_W-1:0] now, logic [REQ_W-1:0] req);
			logic [TEMPO_W-1:0] prev;
			logic [TIME_W-1:0]  iv;
			logic [63:0]        total;
			int unsigned        hits;
			int unsigned        i;
			tempo_result_t      r;
			prev  = tempo;
			total = '0;
			hits  = 0;
			r     = '0;
			if (op == OP_REQUEST) begin
				n_requests++;
				tempo = clamp_tenths(64'(req));
			end else begin
				n_taps++;
				// Drop the window after a long pause (modulo 2^32 difference)
				if (ntaps > 0 && TIME_W'(now - taps[ntaps-1]) > TIME_W'(gap_ms))
					ntaps = 0;
				// Full window: discard the oldest tap
				if (ntaps >= WINDOW) begin
					for (i = 0; i < WINDOW - 1; i++)
						taps[i] = taps[i+1];
					ntaps = WINDOW - 1;
				end
				taps[ntaps] = now;
				ntaps++;
				for (i = 1; i < ntaps; i++) begin
					iv = taps[i] - taps[i-1];
					if (iv >= TIME_W'(min_iv) && iv <= TIME_W'(max_iv)) begin
						total += 64'(iv);
						hits++;
					end
				end
				if (hits > 0) begin
					r.estimate = 1'b1;
					n_estimates++;
					if (total == 0)
						tempo = TEMPO_MAX;
					else
						tempo = clamp_tenths((64'd1200000 * 64'(hits) + total) / (2 * total));
				end
			end
			r.tempo     = tempo;
			r.changed   = (tempo != prev);
			r.intervals = (hits > 7) ? 3'd7 : 3'(hits);
			if (r.changed)
				n_changes++;
			expected_tempos.push_back(r);
		endfunction

		function void check_result(tempo_result_t got);
			tempo_result_t want;
			if (expected_tempos.size() == 0) begin
				n_errors++;
				if (n_errors <= MAX_REPORTS)
					$display("unexpected result: tempo %0d changed %0b estimate %0b intervals %0d",
						got.tempo, got.changed, got.estimate, got.intervals);
				return;
			end
			want = expected_tempos.pop_front();
			n_checked++;
			if (got.tempo !== want.tempo || got.changed !== want.changed ||
					got.estimate !== want.estimate || got.intervals !== want.intervals) begin
				n_errors++;
				if (n_errors <= MAX_REPORTS)
					$display("result %0d mismatch: expected tempo %0d chg %0b est %0b iv %0d, got tempo %0d chg %0b est %0b iv %0d",
						n_checked, want.tempo, want.changed, want.estimate, want.intervals,
						got.tempo, got.changed, got.estimate, got.intervals);
			end
		endfunction

		function int unsigned pending();
			return expected_tempos.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               item_valid;
	logic               item_ready;
	logic               opcode;
	logic [TIME_W-1:0]  tap_time_ms;
	logic [REQ_W-1:0]   tempo_request_tenths;
	logic               result_valid;
	logic               result_ready;
	logic [TEMPO_W-1:0] tempo_tenths;
	logic               tempo_changed;
	logic               estimate_made;
	logic [2:0]         valid_intervals;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [CFG_W-1:0]   cfg_data;

	tempo_tracker tracker = new();

	// Stimulus and receiver controls
	rx_mode_t          rx_mode = RX_ALWAYS;
	logic              hold_req = 1'b0;
	int unsigned       n_holds = 0;
	bit                idle_on = 1'b0;
	int unsigned       burst_left = 1;
	logic [TIME_W-1:0] now_ms;
	logic [TIME_W-1:0] beat_ms;

	tap_tempo_estimator_top i_dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.item_valid           (item_valid),
		.item_ready           (item_ready),
		.opcode               (opcode),
		.tap_time_ms          (tap_time_ms),
		.tempo_request_tenths (tempo_request_tenths),
		.result_valid         (result_valid),
		.result_ready         (result_ready),
		.tempo_tenths         (tempo_tenths),
		.tempo_changed        (tempo_changed),
		.estimate_made        (estimate_made),
		.valid_intervals      (valid_intervals),
		.cfg_valid            (cfg_valid),
		.cfg_ready            (cfg_ready),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data)
	);

	always #2 clk = ~clk;

	// Check every result transaction
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			tracker.check_result({tempo_tenths, tempo_changed, estimate_made, valid_intervals});
	end

	// Drive result_ready on the current pattern; a hold request forces a long stall
	initial begin
		int unsigned tick;
		int unsigned stall_left;
		tick = 0;
		stall_left = 0;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_req) begin
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				n_holds++;
			end
			case (rx_mode)
			RX_ALWAYS:   result_ready <= 1'b1;
			RX_RANDOM:   result_ready <= ($urandom_range(99) < 60);
			RX_PERIODIC: result_ready <= ((tick % 7) < 4);
			default: begin
				if (stall_left != 0) begin
					stall_left--;
					result_ready <= 1'b0;
				end else if ($urandom_range(9) == 0) begin
					stall_left = $urandom_range(10, 1);
					result_ready <= 1'b0;
				end else begin
					result_ready <= 1'b1;
				end
			end
			endcase
		end
	end

	// Offer one item and hold it until accepted; with idle gaps on, insert a gap at the end of a burst
	task automatic send_item(op_t op, logic [TIME_W-1:0] t, logic [REQ_W-1:0] req);
		int unsigned gap_len;
		@(negedge clk);
		item_valid           <= 1'b1;
		opcode               <= op;
		tap_time_ms          <= t;
		tempo_request_tenths <= req;
		do @(posedge clk); while (!item_ready);
		tracker.predict_tempo(op, t, req);
		if (idle_on) begin
			if (burst_left > 0)
				burst_left--;
			if (burst_left == 0) begin
				gap_len = $urandom_range(12, 1);
				@(negedge clk);
				item_valid <= 1'b0;
				repeat (gap_len - 1) @(negedge clk);
				burst_left = $urandom_range(16, 1);
			end
		end
	endtask

	task automatic write_cfg(cfg_reg_t idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		tracker.write_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_limits(logic [CFG_W-1:0] gap, logic [CFG_W-1:0] lo,
			logic [CFG_W-1:0] hi, logic [CFG_W-1:0] init);
		write_cfg(REG_RESET_GAP, gap);
		write_cfg(REG_MIN_IV, lo);
		write_cfg(REG_MAX_IV, hi);
		write_cfg(REG_INIT_TEMPO, init);
	endtask

	task automatic drain();
		int n;
		n = 0;
		while (tracker.pending() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
	endtask

	// Interval that keeps the window alive and counts as valid, when one exists
	function automatic logic [TIME_W-1:0] pick_beat();
		int unsigned lo;
		int unsigned hi;
		lo = 32'(tracker.min_iv);
		hi = (tracker.max_iv < tracker.gap_ms) ? 32'(tracker.max_iv) : 32'(tracker.gap_ms);
		if (lo > hi)
			return $urandom_range(65535);
		return $urandom_range(hi, lo);
	endfunction

	function automatic logic [REQ_W-1:0] pick_request();
		case ($urandom_range(3))
		0:       return REQ_W'($urandom_range(199));
		1:       return REQ_W'($urandom_range(3000, 200));
		2:       return REQ_W'($urandom_range(65535, 3001));
		default: return REQ_W'($urandom());
		endcase
	endfunction

	// Mostly steady tap trains, with restarts, jitter, wild timestamps and requests
	task automatic random_item();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 10) begin
			send_item(OP_REQUEST, $urandom(), pick_request());
		end else begin
			if (roll < 15) begin
				now_ms = $urandom();
			end else if (roll < 22) begin
				now_ms += $urandom_range(65535);
			end else if (roll < 27) begin
				beat_ms = pick_beat();
				now_ms += TIME_W'(tracker.gap_ms) + 1 + $urandom_range(500);
			end else if (roll < 45) begin
				now_ms += pick_beat();
			end else begin
				now_ms += beat_ms;
			end
			send_item(OP_TAP, now_ms, REQ_W'($urandom()));
		end
	endtask

	task automatic run_phase(int n_items, rx_mode_t rxm, bit idle, int hold_at);
		int i;
		rx_mode    = rxm;
		idle_on    = idle;
		burst_left = $urandom_range(16, 1);
		beat_ms    = pick_beat();
		for (i = 0; i < n_items; i++) begin
			if (i == hold_at)
				hold_req = 1'b1;
			random_item();
		end
		@(negedge clk);
		item_valid <= 1'b0;
		drain();
		repeat (4) @(posedge clk);
	endtask

	// Directed items under the reset limits: clamps, wrap, full window, borders
	task automatic directed_items();
		logic [TIME_W-1:0] t;
		send_item(OP_REQUEST, 32'h0000_0000, 16'd0);
		send_item(OP_REQUEST, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(OP_REQUEST, $urandom(), 16'd3000);
		send_item(OP_REQUEST, $urandom(), 16'd1200);
		send_item(OP_REQUEST, $urandom(), 16'd199);
		send_item(OP_REQUEST, $urandom(), 16'd3001);
		t = 32'hFFFF_FE00;
		send_item(OP_TAP, t, 16'hFFFF);
		// Steady 500 ms taps across the timestamp wrap, past a full window
		repeat (6) begin
			t += 500;
			send_item(OP_TAP, t, REQ_W'($urandom()));
		end
		t += 100;
		send_item(OP_TAP, t, REQ_W'($urandom()));
		t += 2000;
		send_item(OP_TAP, t, REQ_W'($urandom()));
		t += 2001;
		send_item(OP_TAP, t, REQ_W'($urandom()));
		t += 200;
		send_item(OP_TAP, t, REQ_W'($urandom()));
		// Earlier timestamp reads as a huge gap
		t -= 1;
		send_item(OP_TAP, t, REQ_W'($urandom()));
		t += 199;
		send_item(OP_TAP, t, REQ_W'($urandom()));
		send_item(OP_REQUEST, 32'hFFFF_FFFF, 16'h8000);
		@(negedge clk);
		item_valid <= 1'b0;
		drain();
		repeat (4) @(posedge clk);
	endtask

	// Main sequence
	initial begin
		logic [CFG_W-1:0] lo;
		arst_n               = 1'b0;
		item_valid           = 1'b0;
		opcode               = OP_TAP;
		tap_time_ms          = '0;
		tempo_request_tenths = '0;
		cfg_valid            = 1'b0;
		cfg_index            = REG_RESET_GAP;
		cfg_data             = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		directed_items();

		// Widest limits, timestamps starting just below the wrap
		set_limits(16'hFFFF, 16'd1, 16'hFFFF, 16'h0FFF);
		now_ms = 32'hFFFF_F000;
		run_phase(220, RX_RANDOM, 1'b1, -1);

		// Minimum above maximum and a 1 ms reset gap: nothing is ever averaged
		set_limits(16'd1, 16'hFFFF, 16'd1, 16'h0000);
		run_phase(80, RX_PERIODIC, 1'b1, -1);

		// All limits zero: coinciding taps give a zero sum
		set_limits(16'd0, 16'd0, 16'd0, 16'hF4B0);
		run_phase(100, RX_ALWAYS, 1'b0, -1);

		// Reset values again, with one long receiver hold-off
		set_limits(RESET_GAP_DEF, MIN_IV_DEF, MAX_IV_DEF, 16'(INIT_TEMPO_DEF));
		run_phase(300, RX_BURSTY, 1'b1, 100);

		// Random limits
		repeat (2) begin
			lo = CFG_W'($urandom_range(400, 1));
			set_limits(CFG_W'($urandom_range(6000, 300)), lo,
				CFG_W'($urandom_range(4000, lo + 50)), CFG_W'($urandom()));
			now_ms = $urandom();
			run_phase(275, RX_RANDOM, 1'b1, -1);
		end

		drain();
		repeat (SETTLE) @(posedge clk);
		if (tracker.pending() != 0) begin
			$display("%0d expected results never arrived", tracker.pending());
			tracker.n_errors += tracker.pending();
		end
		$display("covered %0d taps and %0d requests, %0d estimates, %0d tempo changes",
			tracker.n_taps, tracker.n_requests, tracker.n_estimates, tracker.n_changes);
		$display("%0d results checked, %0d register writes, %0d long hold-offs, %0d failures",
			tracker.n_checked, tracker.n_cfg, n_holds, tracker.n_errors);
		if (tracker.n_errors == 0) begin
			$display("tap_tempo_estimator_top_tb OK");
		end else begin
			$display("tap_tempo_estimator_top_tb NOT OK");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#4_000_000;
		$display("timeout with %0d results outstanding", tracker.pending());
		$display("tap_tempo_estimator_top_tb NOT OK");
		$finish;
	end

endmodule

[tap_tempo_estimator_top.f]
hw/rtl/tte_pkg.sv
hw/rtl/tte_window.sv
hw/rtl/tte_div.sv
hw/rtl/tap_tempo_estimator_top.sv
tb/tap_tempo_estimator_top_tb.sv
